@@ src/phpt_pkg.sv @@
// ----------------------------------------------------------------------------
// phpt_pkg
// Shared types and constants of the pairing engine and its peer table.
// ----------------------------------------------------------------------------
package phpt_pkg;

   // peer table depth and derived widths
   localparam int PEERS  = 8;
   localparam int IDX_W  = (PEERS > 1) ? $clog2(PEERS) : 1;
   localparam int CNT_W  = $clog2(PEERS + 1);
   localparam int SLOT_W = 4;
   localparam logic [SLOT_W-1:0] NO_SLOT = 4'hF;

   localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROLE      = 3'd0,
      CSR_VERSION   = 3'd1,
      CSR_BCAST_INT = 3'd2,
      CSR_LINK_TO   = 3'd3,
      CSR_PEER_TTL  = 3'd4,
      CSR_MIN_HDR   = 3'd5,
      CSR_MIN_CMD   = 3'd6
   } csr_index_type;

   // input opcodes
   typedef enum logic [1:0] {
      OP_POLL      = 2'd0,
      OP_RECEIVE   = 2'd1,
      OP_DISCOVERY = 2'd2,
      OP_RESET     = 2'd3
   } opcode_type;

   // received message types
   typedef enum logic [2:0] {
      RX_PAIR_REQ = 3'd0,
      RX_IDENTITY = 3'd1,
      RX_CONFIRM  = 3'd2,
      RX_ACK      = 3'd3,
      RX_COMMAND  = 3'd4
   } msg_type_type;

   // result kinds
   typedef enum logic [1:0] {
      EV_SEND    = 2'd0,
      EV_COMMAND = 2'd1,
      EV_STATUS  = 2'd2
   } event_kind_type;

   // sent packet types
   typedef enum logic [1:0] {
      SEND_PAIR_REQ = 2'd0,
      SEND_IDENTITY = 2'd1,
      SEND_CONFIRM  = 2'd2,
      SEND_ACK      = 2'd3
   } send_type_type;

   // one peer table entry as held in memory
   typedef struct packed {
      logic [47:0] mac;
      logic [63:0] tag;
      logic [31:0] seen;
      logic        confirmed;
      logic        acked;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ src/phpt_ram.sv @@
// ----------------------------------------------------------------------------
// phpt_ram
// Generic memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module phpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/pairing_handshake_peer_table_unit.sv @@
// ----------------------------------------------------------------------------
// pairing_handshake_peer_table_unit
// Pairing engine for a wireless link with an aging peer table.
// ----------------------------------------------------------------------------
// One input transfer is taken at a time and answered by one to three result
// transfers, the status item always last. The peer table sits in a memory with
// registered read data; a poll tick, or a received packet whose header is not
// rejected, sweeps it once, one entry per cycle. A poll that times out the link
// goes on to a link reset. Result transfers are held while the sink keeps
// rsp_tready low. The next request is taken once the status transfer completes.
module pairing_handshake_peer_table_unit
   import phpt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // now_ms, src_mac, msg_type, proto_version, packet_length, peer_tag,
   // enable_flag, zero pad
   input  logic [167:0]         req_tdata,
   // opcode
   input  logic [1:0]           req_tuser,
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // send_type, dest_mac, accepted, paired_now, peers_in_use
   output logic [55:0]          rsp_tdata,
   // event_kind
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast,
   // configuration writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_PRUNE, S_POLL, S_MATCH, S_RX, S_LR_RD, S_LR_WR, S_OUT
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic        role_ff, role_in;
   logic [7:0]  pver_ff, pver_in;
   logic [31:0] bint_ff, bint_in;
   logic [31:0] lto_ff, lto_in;
   logic [31:0] ttl_ff, ttl_in;
   logic [7:0]  minh_ff, minh_in;
   logic [7:0]  minc_ff, minc_in;

   // captured request
   logic [31:0] now_ff, now_in;
   logic [47:0] mac_ff, mac_in;
   logic [2:0]  mtype_ff, mtype_in;
   logic [7:0]  len_ff, len_in;
   logic [63:0] tag_ff, tag_in;
   logic        acc_ff, acc_in;

   // link state
   logic [PEERS-1:0]  valid_ff, valid_in;
   logic              paired_ff, paired_in;
   logic              await_ff, await_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [47:0]       lmac_ff, lmac_in;
   logic [31:0]       act_ff, act_in;
   logic [31:0]       ctime_ff, ctime_in;
   logic [31:0]       bcast_ff, bcast_in;
   logic              disc_ff, disc_in;

   // sweep control
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;

   // sweep results
   logic             have_unacked_ff, have_unacked_in;
   logic             have_tgt_ff, have_tgt_in;
   logic [IDX_W-1:0] tgt_idx_ff, tgt_idx_in;
   entry_type        tgt_word_ff, tgt_word_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   entry_type        hit_word_ff, hit_word_in;

   // pending event items
   logic [1:0]  ev_n_ff, ev_n_in;
   logic [1:0]  ev_kind_ff [2];
   logic [1:0]  ev_kind_in [2];
   logic [1:0]  ev_type_ff [2];
   logic [1:0]  ev_type_in [2];
   logic [47:0] ev_mac_ff [2];
   logic [47:0] ev_mac_in [2];
   logic [1:0]  out_idx_ff, out_idx_in;

   // memory port
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type        ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type        rd_word;

   phpt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(PEERS)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rd_word = entry_type'(ram_rdata);

   // first free entry
   logic             free_ok;
   logic [IDX_W-1:0] free_idx;
   always_comb begin
      free_ok  = 1'b0;
      free_idx = '0;
      for (int i = PEERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_ok  = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // result channel
   logic out_last;
   assign out_last   = (out_idx_ff == ev_n_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tlast  = out_last;
   assign rsp_tuser  = out_last ? EV_STATUS : ev_kind_ff[out_idx_ff[0]];
   assign rsp_tdata  = {4'($countones(valid_ff)), paired_ff,
                        out_last ? acc_ff : 1'b0,
                        out_last ? 48'd0 : ev_mac_ff[out_idx_ff[0]],
                        out_last ? 2'd0 : ev_type_ff[out_idx_ff[0]]};

   // next state logic
   always_comb begin
      logic        lr_apply;
      logic        expire;
      logic        pre;
      logic        up_ok;
      logic        wr_rx;
      logic        do_upsert;
      logic [IDX_W-1:0] up_idx;
      entry_type   w;
      logic [31:0] cdiff;

      lr_apply = 1'b0;
      expire   = 1'b0;
      pre      = 1'b0;
      up_ok    = 1'b0;
      wr_rx    = 1'b0;
      do_upsert = 1'b0;
      up_idx   = '0;
      w        = '0;
      cdiff    = '0;

      state_in = state_ff;
      role_in = role_ff; pver_in = pver_ff; bint_in = bint_ff; lto_in = lto_ff;
      ttl_in = ttl_ff; minh_in = minh_ff; minc_in = minc_ff;
      now_in = now_ff; mac_in = mac_ff; mtype_in = mtype_ff;
      len_in = len_ff; tag_in = tag_ff; acc_in = acc_ff;
      valid_in = valid_ff; paired_in = paired_ff; await_in = await_ff;
      slot_in = slot_ff; lmac_in = lmac_ff; act_in = act_ff; ctime_in = ctime_ff;
      bcast_in = bcast_ff; disc_in = disc_ff;
      cnt_in = cnt_ff; pend_in = 1'b0; pidx_in = pidx_ff;
      have_unacked_in = have_unacked_ff; have_tgt_in = have_tgt_ff;
      tgt_idx_in = tgt_idx_ff; tgt_word_in = tgt_word_ff;
      hit_in = hit_ff; hit_idx_in = hit_idx_ff; hit_word_in = hit_word_ff;
      ev_n_in = ev_n_ff; ev_kind_in = ev_kind_ff; ev_type_in = ev_type_ff;
      ev_mac_in = ev_mac_ff; out_idx_in = out_idx_ff;
      ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROLE:      role_in = csr_wdata[0];
            CSR_VERSION:   pver_in = csr_wdata[7:0];
            CSR_BCAST_INT: bint_in = csr_wdata;
            CSR_LINK_TO:   lto_in  = csr_wdata;
            CSR_PEER_TTL:  ttl_in  = csr_wdata;
            CSR_MIN_HDR:   minh_in = csr_wdata[7:0];
            CSR_MIN_CMD:   minc_in = csr_wdata[7:0];
            default: ;
         endcase
      end

      // table sweep, one read per cycle
      if (state_ff == S_PRUNE || state_ff == S_MATCH) begin
         if (cnt_ff < CNT_W'(PEERS)) begin
            ram_raddr = cnt_ff[IDX_W-1:0];
            pidx_in   = cnt_ff[IDX_W-1:0];
            pend_in   = 1'b1;
            cnt_in    = cnt_ff + CNT_W'(1);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               now_in   = req_tdata[31:0];
               mac_in   = req_tdata[79:32];
               mtype_in = req_tdata[82:80];
               len_in   = req_tdata[98:91];
               tag_in   = req_tdata[162:99];
               acc_in   = 1'b0;
               ev_n_in  = 2'd0;
               out_idx_in = 2'd0;
               cnt_in   = '0;
               have_unacked_in = 1'b0;
               have_tgt_in = 1'b0;
               hit_in   = 1'b0;
               unique case (opcode_type'(req_tuser))
                  OP_POLL: state_in = S_PRUNE;
                  OP_RECEIVE: begin
                     if (req_tdata[98:91] < minh_ff || req_tdata[90:83] != pver_ff) begin
                        state_in = S_OUT;
                     end else begin
                        state_in = S_MATCH;
                     end
                  end
                  OP_DISCOVERY: begin
                     disc_in = req_tdata[163];
                     if (req_tdata[163] && !paired_ff) bcast_in = '0;
                     state_in = S_OUT;
                  end
                  OP_RESET: state_in = S_LR_RD;
               endcase
            end
         end

         // age out entries and pick the confirm target
         S_PRUNE: begin
            if (pend_ff) begin
               expire = valid_ff[pidx_ff] && ((now_ff - rd_word.seen) > ttl_ff);
               if (expire) begin
                  valid_in[pidx_ff] = 1'b0;
                  ram_we    = 1'b1;
                  ram_waddr = pidx_ff;
                  ram_wdata = '0;
                  if (slot_ff == SLOT_W'(pidx_ff)) lr_apply = 1'b1;
               end else if (valid_ff[pidx_ff] && !have_unacked_ff) begin
                  if (!rd_word.acked) begin
                     have_unacked_in = 1'b1;
                     have_tgt_in = 1'b1;
                     tgt_idx_in  = pidx_ff;
                     tgt_word_in = rd_word;
                  end else if (!have_tgt_ff) begin
                     have_tgt_in = 1'b1;
                     tgt_idx_in  = pidx_ff;
                     tgt_word_in = rd_word;
                  end
               end
            end else if (cnt_ff == CNT_W'(PEERS)) begin
               state_in = S_POLL;
            end
         end

         // broadcast, confirm, or link timeout
         S_POLL: begin
            state_in = S_OUT;
            cdiff = now_ff - ctime_ff;
            if (!role_ff) begin
               if (disc_ff && !paired_ff) begin
                  if ((now_ff - bcast_ff) >= bint_ff) begin
                     ev_kind_in[ev_n_in[0]] = EV_SEND;
                     ev_type_in[ev_n_in[0]] = SEND_PAIR_REQ;
                     ev_mac_in[ev_n_in[0]]  = BCAST_MAC;
                     ev_n_in  = ev_n_in + 2'd1;
                     bcast_in = now_ff;
                  end
                  if (have_tgt_ff && (!tgt_word_ff.confirmed || cdiff >= bint_ff)) begin
                     ev_kind_in[ev_n_in[0]] = EV_SEND;
                     ev_type_in[ev_n_in[0]] = SEND_CONFIRM;
                     ev_mac_in[ev_n_in[0]]  = tgt_word_ff.mac;
                     ev_n_in = ev_n_in + 2'd1;
                     w = tgt_word_ff;
                     w.confirmed = 1'b1;
                     w.acked     = 1'b0;
                     ram_we    = 1'b1;
                     ram_waddr = tgt_idx_ff;
                     ram_wdata = w;
                     slot_in   = SLOT_W'(tgt_idx_ff);
                     await_in  = 1'b1;
                     ctime_in  = now_ff;
                     lmac_in   = tgt_word_ff.mac;
                  end
               end else if (paired_ff && ((now_ff - act_ff) > lto_ff)) begin
                  state_in = S_LR_RD;
               end
            end else if (paired_ff && ((now_ff - act_ff) > lto_ff)) begin
               state_in = S_LR_RD;
            end
         end

         // look up the sender
         S_MATCH: begin
            if (pend_ff) begin
               if (valid_ff[pidx_ff] && rd_word.mac == mac_ff && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = pidx_ff;
                  hit_word_in = rd_word;
               end
            end else if (cnt_ff == CNT_W'(PEERS)) begin
               state_in = S_RX;
            end
         end

         // act on the received message
         S_RX: begin
            state_in = S_OUT;
            pre   = paired_ff && (mac_ff == lmac_ff);
            up_ok = hit_ff || free_ok;
            up_idx = hit_ff ? hit_idx_ff : free_idx;
            if (hit_ff) begin
               w = hit_word_ff;
            end else begin
               w.mac = mac_ff;
               w.tag = tag_ff;
               w.seen = now_ff;
               w.confirmed = 1'b0;
               w.acked = 1'b0;
            end
            if (pre) begin
               act_in = now_ff;
               if (hit_ff) begin
                  w.seen = now_ff;
                  wr_rx  = 1'b1;
               end
            end
            unique case (mtype_ff)
               RX_PAIR_REQ: begin
                  if (role_ff) begin
                     acc_in = 1'b1;
                     if (!paired_ff) begin
                        do_upsert = 1'b1;
                        ev_kind_in[ev_n_in[0]] = EV_SEND;
                        ev_type_in[ev_n_in[0]] = SEND_IDENTITY;
                        ev_mac_in[ev_n_in[0]]  = mac_ff;
                        ev_n_in = ev_n_in + 2'd1;
                     end
                  end
               end
               RX_IDENTITY: begin
                  if (!role_ff) begin
                     acc_in = 1'b1;
                     do_upsert = 1'b1;
                  end
               end
               RX_CONFIRM: begin
                  if (role_ff) begin
                     acc_in = 1'b1;
                     do_upsert = 1'b1;
                     if (up_ok) begin
                        paired_in = 1'b1;
                        slot_in   = SLOT_W'(up_idx);
                        lmac_in   = mac_ff;
                        act_in    = now_ff;
                        w.acked   = 1'b1;
                        ev_kind_in[ev_n_in[0]] = EV_SEND;
                        ev_type_in[ev_n_in[0]] = SEND_ACK;
                        ev_mac_in[ev_n_in[0]]  = mac_ff;
                        ev_n_in = ev_n_in + 2'd1;
                     end
                  end
               end
               RX_ACK: begin
                  if (!role_ff && await_ff && mac_ff == lmac_ff) begin
                     acc_in    = 1'b1;
                     paired_in = 1'b1;
                     await_in  = 1'b0;
                     act_in    = now_ff;
                     disc_in   = 1'b0;
                     if (hit_ff) begin
                        w.acked = 1'b1;
                        w.seen  = now_ff;
                        wr_rx   = 1'b1;
                     end
                  end
               end
               RX_COMMAND: begin
                  acc_in = 1'b1;
                  if (len_ff >= minc_ff) begin
                     ev_kind_in[ev_n_in[0]] = EV_COMMAND;
                     ev_type_in[ev_n_in[0]] = SEND_PAIR_REQ;
                     ev_mac_in[ev_n_in[0]]  = mac_ff;
                     ev_n_in = ev_n_in + 2'd1;
                  end
               end
               default: ;
            endcase
            // insert or refresh the sender entry
            if (do_upsert && up_ok) begin
               w.tag  = tag_ff;
               w.seen = now_ff;
               wr_rx  = 1'b1;
               if (!hit_ff) valid_in[up_idx] = 1'b1;
            end
            if (wr_rx) begin
               ram_we    = 1'b1;
               ram_waddr = up_idx;
               ram_wdata = w;
            end
         end

         // link reset: fetch the linked entry
         S_LR_RD: begin
            if (slot_ff < SLOT_W'(PEERS)) begin
               ram_raddr = slot_ff[IDX_W-1:0];
               state_in  = S_LR_WR;
            end else begin
               lr_apply = 1'b1;
               state_in = S_OUT;
            end
         end

         // link reset: clear its confirm and ack flags
         S_LR_WR: begin
            w = rd_word;
            w.confirmed = 1'b0;
            w.acked     = 1'b0;
            ram_we    = 1'b1;
            ram_waddr = slot_ff[IDX_W-1:0];
            ram_wdata = w;
            lr_apply  = 1'b1;
            state_in  = S_OUT;
         end

         // result transfers
         S_OUT: begin
            if (rsp_tready) begin
               if (out_last) begin
                  state_in = S_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 2'd1;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase

      // clear the link
      if (lr_apply) begin
         paired_in = 1'b0;
         await_in  = 1'b0;
         slot_in   = NO_SLOT;
         lmac_in   = '0;
         act_in    = '0;
         ctime_in  = '0;
         disc_in   = 1'b1;
         bcast_in  = '0;
      end
   end

   // state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         role_ff   <= 1'b0;
         pver_ff   <= 8'd1;
         bint_ff   <= 32'd1000;
         lto_ff    <= 32'd3000;
         ttl_ff    <= 32'd10000;
         minh_ff   <= 8'd64;
         minc_ff   <= 8'd96;
         valid_ff  <= '0;
         paired_ff <= 1'b0;
         await_ff  <= 1'b0;
         slot_ff   <= NO_SLOT;
         lmac_ff   <= '0;
         act_ff    <= '0;
         ctime_ff  <= '0;
         bcast_ff  <= '0;
         disc_ff   <= 1'b1;
         cnt_ff    <= '0;
         pend_ff   <= 1'b0;
         ev_n_ff   <= 2'd0;
         out_idx_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         role_ff   <= role_in;
         pver_ff   <= pver_in;
         bint_ff   <= bint_in;
         lto_ff    <= lto_in;
         ttl_ff    <= ttl_in;
         minh_ff   <= minh_in;
         minc_ff   <= minc_in;
         valid_ff  <= valid_in;
         paired_ff <= paired_in;
         await_ff  <= await_in;
         slot_ff   <= slot_in;
         lmac_ff   <= lmac_in;
         act_ff    <= act_in;
         ctime_ff  <= ctime_in;
         bcast_ff  <= bcast_in;
         disc_ff   <= disc_in;
         cnt_ff    <= cnt_in;
         pend_ff   <= pend_in;
         ev_n_ff   <= ev_n_in;
         out_idx_ff <= out_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      now_ff   <= now_in;
      mac_ff   <= mac_in;
      mtype_ff <= mtype_in;
      len_ff   <= len_in;
      tag_ff   <= tag_in;
      acc_ff   <= acc_in;
      pidx_ff  <= pidx_in;
      have_unacked_ff <= have_unacked_in;
      have_tgt_ff <= have_tgt_in;
      tgt_idx_ff  <= tgt_idx_in;
      tgt_word_ff <= tgt_word_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_word_ff <= hit_word_in;
      ev_kind_ff  <= ev_kind_in;
      ev_type_ff  <= ev_type_in;
      ev_mac_ff   <= ev_mac_in;
   end

endmodule

@@ test/tb_pairing_handshake_peer_table_unit.sv @@
// ----------------------------------------------------------------------------
// tb_pairing_handshake_peer_table_unit
// Self-checking bench for the pairing engine and its peer table.
// ----------------------------------------------------------------------------
// A directed table walks both roles, the rejection cases, table overflow,
// aging and link reset. Random phases follow, each with its own register
// setting and one of four idle patterns. Every request transfer is fed to a
// local model of the pairing engine, and every result transfer is checked
// against the oldest predicted item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pairing_handshake_peer_table_unit;
   import phpt_pkg::*;

   // one request as seen by the engine
   typedef struct {
      opcode_type  op;
      logic [31:0] now;
      logic [47:0] mac;
      logic [2:0]  mtype;
      logic [7:0]  ver;
      logic [7:0]  len;
      logic [63:0] tag;
      logic        en;
      logic        chk;     // status values below are typed in
      logic        t_acc;
      logic        t_paired;
      logic [3:0]  t_count;
   } request_type;

   // one result item
   typedef struct {
      event_kind_type kind;
      send_type_type  stype;
      logic [47:0]    mac;
      logic           acc;
      logic           paired;
      logic [3:0]     count;
      logic           last;
   } result_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [167:0]   req_tdata = '0;
   logic [1:0]     req_tuser = '0;
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [55:0]    rsp_tdata;
   logic [1:0]     rsp_tuser;
   logic           rsp_tlast;
   logic           csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]    csr_wdata = '0;

   int             errors = 0;
   int             send_idle_pct = 0;
   int             stall_pct = 0;
   result_type     pending_results[$];
   result_type     step_items[$];

   // model registers
   logic        m_role;
   logic [7:0]  m_version;
   logic [31:0] m_bcast_int, m_link_to, m_ttl;
   logic [7:0]  m_min_hdr, m_min_cmd;

   // model state
   logic        e_valid[PEERS];
   logic [47:0] e_mac[PEERS];
   logic [63:0] e_tag[PEERS];
   logic [31:0] e_seen[PEERS];
   logic        e_conf[PEERS];
   logic        e_acked[PEERS];
   logic        lk_paired, lk_awaiting, disc_on;
   logic [3:0]  lk_slot, occ_count;
   logic [47:0] lk_mac;
   logic [31:0] lk_activity, lk_conf_time, bcast_time;

   logic [47:0] mac_pool[10];
   logic [31:0] clock_ms = 32'd20000;

   always #1 clock = ~clock;

   pairing_handshake_peer_table_unit i_dut (.*);

   // ------------------------------------------------------------------
   // pairing engine model
   // ------------------------------------------------------------------
   task automatic model_reset();
      m_role = 1'b0; m_version = 8'd1; m_bcast_int = 32'd1000;
      m_link_to = 32'd3000; m_ttl = 32'd10000; m_min_hdr = 8'd64; m_min_cmd = 8'd96;
      for (int i = 0; i < PEERS; i++) begin
         e_valid[i] = 0; e_mac[i] = 0; e_tag[i] = 0; e_seen[i] = 0;
         e_conf[i] = 0; e_acked[i] = 0;
      end
      lk_paired = 0; lk_awaiting = 0; lk_slot = NO_SLOT; lk_mac = 0;
      lk_activity = 0; lk_conf_time = 0; bcast_time = 0; disc_on = 1; occ_count = 0;
   endtask

   task automatic model_config(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      case (idx)
         CSR_ROLE:      m_role = val[0];
         CSR_VERSION:   m_version = val[7:0];
         CSR_BCAST_INT: m_bcast_int = val;
         CSR_LINK_TO:   m_link_to = val;
         CSR_PEER_TTL:  m_ttl = val;
         CSR_MIN_HDR:   m_min_hdr = val[7:0];
         CSR_MIN_CMD:   m_min_cmd = val[7:0];
         default: ;
      endcase
   endtask

   task automatic add_item(input event_kind_type k, input send_type_type s,
                           input logic [47:0] mac, input logic acc);
      result_type r;
      r.kind = k; r.stype = s; r.mac = mac; r.acc = acc;
      r.paired = 0; r.count = 0; r.last = 0;
      if (step_items.size() < 3) step_items.push_back(r);
   endtask

   task automatic recount();
      occ_count = 0;
      for (int i = 0; i < PEERS; i++) if (e_valid[i]) occ_count++;
   endtask

   function automatic int find_peer(input logic [47:0] mac);
      for (int i = 0; i < PEERS; i++) if (e_valid[i] && e_mac[i] == mac) return i;
      return -1;
   endfunction

   task automatic clear_link();
      if (lk_slot < PEERS) begin
         e_acked[lk_slot] = 0; e_conf[lk_slot] = 0;
      end
      lk_paired = 0; lk_awaiting = 0; lk_slot = NO_SLOT; lk_mac = 0;
      lk_activity = 0; lk_conf_time = 0; disc_on = 1; bcast_time = 0;
   endtask

   task automatic store_peer(input logic [63:0] tag, input logic [47:0] mac,
                             input logic [31:0] now, output int slot);
      slot = find_peer(mac);
      if (slot >= 0) begin
         e_tag[slot] = tag; e_seen[slot] = now;
      end else begin
         for (int i = 0; i < PEERS; i++) begin
            if (!e_valid[i] && slot < 0) begin
               e_valid[i] = 1; e_tag[i] = tag; e_mac[i] = mac; e_seen[i] = now;
               e_conf[i] = 0; e_acked[i] = 0; slot = i;
            end
         end
      end
      recount();
   endtask

   task automatic age_peers(input logic [31:0] now);
      for (int i = 0; i < PEERS; i++) begin
         if (e_valid[i] && (now - e_seen[i]) > m_ttl) begin
            if (lk_slot == i) clear_link();
            e_valid[i] = 0; e_mac[i] = 0; e_tag[i] = 0; e_seen[i] = 0;
            e_conf[i] = 0; e_acked[i] = 0;
         end
      end
      recount();
   endtask

   task automatic handle_poll(input logic [31:0] now);
      int t;
      age_peers(now);
      if (m_role == 1'b0) begin
         if (disc_on && !lk_paired && (now - bcast_time) >= m_bcast_int) begin
            add_item(EV_SEND, SEND_PAIR_REQ, BCAST_MAC, 1'b0);
            bcast_time = now;
         end
         if (disc_on && !lk_paired) begin
            t = -1;
            for (int i = 0; i < PEERS; i++) begin
               if (e_valid[i] && !e_acked[i] && (t < 0 || e_acked[t])) t = i;
               else if (e_valid[i] && t < 0) t = i;
            end
            if (t >= 0 && (!e_conf[t] || (now - lk_conf_time) >= m_bcast_int)) begin
               add_item(EV_SEND, SEND_CONFIRM, e_mac[t], 1'b0);
               e_conf[t] = 1; e_acked[t] = 0; lk_slot = 4'(t); lk_awaiting = 1;
               lk_conf_time = now; lk_mac = e_mac[t];
            end
         end else if (lk_paired && (now - lk_activity) > m_link_to) clear_link();
      end else if (lk_paired && (now - lk_activity) > m_link_to) clear_link();
   endtask

   task automatic handle_packet(input request_type q, output logic acc);
      int i;
      acc = 0;
      if (q.len < m_min_hdr || q.ver != m_version) return;
      if (lk_paired && q.mac == lk_mac) begin
         lk_activity = q.now;
         i = find_peer(q.mac);
         if (i >= 0) e_seen[i] = q.now;
      end
      case (q.mtype)
         RX_PAIR_REQ: if (m_role) begin
            acc = 1;
            if (!lk_paired) begin
               store_peer(q.tag, q.mac, q.now, i);
               add_item(EV_SEND, SEND_IDENTITY, q.mac, 1'b0);
            end
         end
         RX_IDENTITY: if (!m_role) begin
            acc = 1; store_peer(q.tag, q.mac, q.now, i);
         end
         RX_CONFIRM: if (m_role) begin
            acc = 1; store_peer(q.tag, q.mac, q.now, i);
            if (i >= 0) begin
               lk_paired = 1; lk_slot = 4'(i); lk_mac = q.mac; lk_activity = q.now;
               add_item(EV_SEND, SEND_ACK, q.mac, 1'b0);
               e_acked[i] = 1;
            end
         end
         RX_ACK: if (!m_role && lk_awaiting && q.mac == lk_mac) begin
            acc = 1; lk_paired = 1; lk_awaiting = 0; lk_activity = q.now;
            i = find_peer(q.mac);
            if (i >= 0) begin
               e_acked[i] = 1; e_seen[i] = q.now;
            end
            disc_on = 0;
         end
         RX_COMMAND: begin
            acc = 1;
            if (q.len >= m_min_cmd) add_item(EV_COMMAND, SEND_PAIR_REQ, q.mac, 1'b0);
         end
         default: ;
      endcase
   endtask

   // runs one accepted request and queues what it causes
   task automatic predict_step(input request_type q);
      logic acc;
      acc = 0;
      step_items.delete();
      case (q.op)
         OP_POLL:      handle_poll(q.now);
         OP_RECEIVE:   handle_packet(q, acc);
         OP_DISCOVERY: begin
            disc_on = q.en;
            if (q.en && !lk_paired) bcast_time = 0;
         end
         default:      clear_link();
      endcase
      add_item(EV_STATUS, SEND_PAIR_REQ, '0, acc);
      foreach (step_items[k]) begin
         step_items[k].paired = lk_paired;
         step_items[k].count = occ_count;
         step_items[k].last = (k == step_items.size() - 1);
         if (q.chk && step_items[k].last) begin
            step_items[k].acc = q.t_acc;
            step_items[k].paired = q.t_paired;
            step_items[k].count = q.t_count;
         end
         pending_results.push_back(step_items[k]);
      end
   endtask

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      result_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0)
            report_mismatch("unexpected transfer", 64'(rsp_tdata), 64'd0);
         else begin
            w = pending_results.pop_front();
            if (rsp_tuser != w.kind)
               report_mismatch("event_kind", 64'(rsp_tuser), 64'(w.kind));
            if (rsp_tdata[1:0] != w.stype)
               report_mismatch("send_type", 64'(rsp_tdata[1:0]), 64'(w.stype));
            if (rsp_tdata[49:2] != w.mac)
               report_mismatch("dest_mac", 64'(rsp_tdata[49:2]), 64'(w.mac));
            if (rsp_tdata[50] != w.acc)
               report_mismatch("accepted", 64'(rsp_tdata[50]), 64'(w.acc));
            if (rsp_tdata[51] != w.paired)
               report_mismatch("paired_now", 64'(rsp_tdata[51]), 64'(w.paired));
            if (rsp_tdata[55:52] != w.count)
               report_mismatch("peers_in_use", 64'(rsp_tdata[55:52]), 64'(w.count));
            if (rsp_tlast != w.last)
               report_mismatch("last_item", 64'(rsp_tlast), 64'(w.last));
         end
      end
   end

   // receiver stalls
   always @(negedge clock) rsp_tready = ($urandom_range(99) >= stall_pct);

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic send_request(input request_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = q.op;
      req_tdata = {4'd0, q.en, q.tag, q.len, q.ver, q.mtype, q.mac, q.now};
      do @(posedge clock); while (!req_tready);
      predict_step(q);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_we = 1'b1; csr_index = idx; csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      model_config(idx, val);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic request_type make_req(input opcode_type op, input logic [31:0] now,
                                            input logic [47:0] mac, input logic [2:0] mt,
                                            input logic [7:0] len, input logic [63:0] tag);
      request_type q;
      q.op = op; q.now = now; q.mac = mac; q.mtype = mt; q.ver = m_version;
      q.len = len; q.tag = tag; q.en = 0; q.chk = 0;
      q.t_acc = 0; q.t_paired = 0; q.t_count = 0;
      return q;
   endfunction

   function automatic request_type typed(input request_type q, input logic acc,
                                         input logic paired, input logic [3:0] cnt);
      q.chk = 1; q.t_acc = acc; q.t_paired = paired; q.t_count = cnt;
      return q;
   endfunction

   // random request, mostly well formed for the current role
   function automatic request_type random_req();
      request_type q;
      int pick;
      pick = $urandom_range(99);
      q = make_req(OP_RECEIVE, clock_ms, mac_pool[$urandom_range(9)], 3'd0, 8'd0,
                   {$urandom, $urandom});
      if (pick < 35) q.op = OP_POLL;
      else if (pick < 42) q.op = OP_DISCOVERY;
      else if (pick < 47) q.op = OP_RESET;
      q.en = 1'($urandom_range(1));
      if ($urandom_range(19) == 0) q.mtype = 3'($urandom_range(7));
      else if ($urandom_range(4) == 0) q.mtype = RX_COMMAND;
      else if (m_role) q.mtype = $urandom_range(1) ? RX_CONFIRM : RX_PAIR_REQ;
      else q.mtype = $urandom_range(1) ? RX_IDENTITY : RX_ACK;
      if (q.mtype == RX_ACK && $urandom_range(3) != 0) q.mac = lk_mac;
      if ($urandom_range(9) == 0) q.ver = 8'($urandom);
      q.len = ($urandom_range(7) == 0) ? 8'($urandom_range(250))
                                       : 8'($urandom_range(250, m_min_hdr));
      return q;
   endfunction

   // ------------------------------------------------------------------
   // directed table and random phases
   // ------------------------------------------------------------------
   localparam logic [47:0] MAC_A = 48'h0000_0000_0000;
   localparam logic [47:0] MAC_B = 48'hA5A5_5A5A_0F0F;

   initial begin
      request_type steps[$];
      request_type q;
      logic [31:0] bint, lto, ttl;
      logic [7:0]  hdr;

      model_reset();
      foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
      mac_pool[0] = BCAST_MAC;
      mac_pool[1] = 48'd0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // controller role at reset settings
      steps.push_back(make_req(OP_POLL, 32'd5000, MAC_A, 3'd0, 8'd64, 64'd0));
      steps.push_back(make_req(OP_RECEIVE, 32'd5010, MAC_A, RX_IDENTITY, 8'd64, '1));
      steps.push_back(typed(make_req(OP_RECEIVE, 32'd5020, MAC_B, RX_IDENTITY, 8'd63, 0),
                            0, 0, 1));
      q = make_req(OP_RECEIVE, 32'd5030, MAC_B, RX_IDENTITY, 8'd250, 0);
      q.ver = 8'd2;
      steps.push_back(typed(q, 0, 0, 1));
      steps.push_back(typed(make_req(OP_RECEIVE, 32'd5040, MAC_B, 3'd7, 8'd100, 0), 0, 0, 1));
      steps.push_back(typed(make_req(OP_RECEIVE, 32'd5050, MAC_B, RX_PAIR_REQ, 8'd100, 0),
                            0, 0, 1));
      steps.push_back(typed(make_req(OP_RECEIVE, 32'd5060, MAC_B, RX_ACK, 8'd100, 0),
                            0, 0, 1));
      steps.push_back(make_req(OP_POLL, 32'd5100, MAC_A, 3'd0, 8'd64, 0));
      steps.push_back(make_req(OP_RECEIVE, 32'd5110, MAC_A, RX_ACK, 8'd64, 0));
      steps.push_back(make_req(OP_RECEIVE, 32'd5120, BCAST_MAC, RX_COMMAND, 8'd96, 0));
      steps.push_back(make_req(OP_RECEIVE, 32'd5130, MAC_A, RX_COMMAND, 8'd95, 0));
      steps.push_back(make_req(OP_POLL, 32'hFFFF_FFFF, MAC_A, 3'd0, 8'd64, 0));
      steps.push_back(make_req(OP_DISCOVERY, 32'd0, MAC_A, 3'd0, 8'd0, 0));
      steps.push_back(make_req(OP_RESET, 32'd0, MAC_A, 3'd0, 8'd0, 0));
      foreach (steps[i]) send_request(steps[i]);
      wait_drained();

      // controlled role, table overflow and pairing
      write_csr(CSR_ROLE, 32'd1);
      write_csr(3'd7, 32'hFFFF_FFFF);
      steps.delete();
      for (int i = 0; i < PEERS; i++)
         steps.push_back(make_req(OP_RECEIVE, 32'd100 + i, 48'h1000 + i, RX_PAIR_REQ,
                                  8'd64, {$urandom, $urandom}));
      steps.push_back(make_req(OP_RECEIVE, 32'd200, MAC_B, RX_PAIR_REQ, 8'd64, 0));
      steps.push_back(make_req(OP_RECEIVE, 32'd210, MAC_B, RX_CONFIRM, 8'd64, 0));
      steps.push_back(make_req(OP_RECEIVE, 32'd220, 48'h1003, RX_CONFIRM, 8'd64, 0));
      steps.push_back(make_req(OP_RECEIVE, 32'd230, 48'h1005, RX_PAIR_REQ, 8'd64, 0));
      steps.push_back(make_req(OP_POLL, 32'd9000, MAC_A, 3'd0, 8'd64, 0));
      foreach (steps[i]) send_request(steps[i]);
      wait_drained();

      // random phases, each with its own setting and one of four idle patterns
      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 52; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 52; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         bint = $urandom_range(1500, 200);
         lto = $urandom_range(6000, 500);
         ttl = $urandom_range(12000, 1000);
         hdr = 8'($urandom_range(100));
         if (ph == 2) begin bint = 0; lto = 0; ttl = '1; hdr = 0; end
         if (ph == 4) begin bint = '1; lto = '1; ttl = 0; hdr = 8'd250; end
         write_csr(CSR_ROLE, 32'(ph % 2));
         write_csr(CSR_VERSION, (ph == 2) ? 32'd255 : (ph == 4) ? 32'd0 : $urandom_range(255));
         write_csr(CSR_BCAST_INT, bint);
         write_csr(CSR_LINK_TO, lto);
         write_csr(CSR_PEER_TTL, ttl);
         write_csr(CSR_MIN_HDR, 32'(hdr));
         write_csr(CSR_MIN_CMD, (ph == 2) ? 32'd250 : (ph == 4) ? 32'd0 : $urandom_range(250));
         for (int n = 0; n < 25; n++) begin
            clock_ms += ($urandom_range(19) == 0) ? $urandom : $urandom_range(1500);
            send_request(random_req());
         end
         wait_drained();
      end

      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ pairing_handshake_peer_table_unit.f @@
src/phpt_pkg.sv
src/phpt_ram.sv
src/pairing_handshake_peer_table_unit.sv
test/tb_pairing_handshake_peer_table_unit.sv
